// ----- hw/rtl/pwi_pkg.sv -----
// ----------------------------------------------------------------------------
// pwi_pkg
// Shared widths, defaults and register codes of the windowed-integral PID.
// ----------------------------------------------------------------------------
`default_nettype none

package pwi_pkg;

  // Field widths of the stream items and registers.
  localparam int MEAS_W   = 16;
  localparam int GAIN_W   = 16;
  localparam int ERR_W    = MEAS_W + 1;
  localparam int DIFF_W   = ERR_W + 1;
  localparam int WIN_W    = 11;
  localparam int OUT_W    = 32;
  localparam int IN_DATA_W  = 2 * MEAS_W;
  localparam int OUT_DATA_W = OUT_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Default parameter values.
  localparam int DEF_WINDOW_DEPTH = 1024;
  localparam int DEF_STEP_MS      = 10;

  // Window length after reset, before saturation to the ring depth.
  localparam int WIN_RESET = 1024;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KP     = 3'd0,
    REG_KI     = 3'd1,
    REG_KD     = 3'd2,
    REG_WINDOW = 3'd3,
    REG_LIMIT  = 3'd4
  } pwi_reg_t;

endpackage

`default_nettype wire

// ----- hw/rtl/pwi_ring.sv -----
// ----------------------------------------------------------------------------
// pwi_ring
// Error ring buffer with running window sum, derivative and clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module pwi_ring #(
  parameter int DEPTH = pwi_pkg::DEF_WINDOW_DEPTH,
  parameter int SUM_W = pwi_pkg::ERR_W + 11
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              step,
  input  logic signed [pwi_pkg::ERR_W-1:0]  err,
  input  logic        [pwi_pkg::WIN_W-1:0]  window,
  output logic                              busy,
  output logic signed [SUM_W-1:0]           sum,
  output logic signed [pwi_pkg::DIFF_W-1:0] diff
);
  import pwi_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic signed [ERR_W-1:0] ring_mem [DEPTH];
  logic signed [ERR_W-1:0] mem_q;
  logic signed [ERR_W-1:0] byp_val;
  logic signed [ERR_W-1:0] rd_data;
  logic signed [ERR_W-1:0] last_err;
  logic                    use_byp;
  logic [AW-1:0]           idx;
  logic [AW-1:0]           idx_next;
  logic [AW:0]             inc;
  logic [AW:0]             clr_cnt;

  assign busy    = (clr_cnt != (AW + 1)'(DEPTH));
  assign rd_data = use_byp ? byp_val : mem_q;

  // Next slot: wrap at the window (a zero window behaves like one) or the depth.
  always_comb begin
    inc = {1'b0, idx} + (AW + 1)'(1);
    if (32'(inc) >= 32'(window) || 32'(inc) >= 32'(DEPTH)) begin
      idx_next = '0;
    end else begin
      idx_next = inc[AW-1:0];
    end
  end

  // The ring itself. The entry at the next slot is fetched as the current one
  // is written, so the old error is ready for the following item.
  always_ff @(posedge clk) begin
    if (busy) begin
      ring_mem[clr_cnt[AW-1:0]] <= '0;
    end else if (step) begin
      ring_mem[idx] <= err;
    end
    if (step) begin
      mem_q <= ring_mem[idx_next];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt  <= '0;
      idx      <= '0;
      use_byp  <= 1'b1;
      byp_val  <= '0;
      sum      <= '0;
      last_err <= '0;
    end else begin
      if (busy) begin
        clr_cnt <= clr_cnt + (AW + 1)'(1);
      end
      if (step) begin
        idx      <= idx_next;
        // When the index stays put, the memory read returns the stale entry.
        use_byp  <= (idx_next == idx);
        byp_val  <= err;
        sum      <= sum - SUM_W'(rd_data) + SUM_W'(err);
        last_err <= err;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      diff <= DIFF_W'(err) - DIFF_W'(last_err);
    end
  end

  a_no_step_while_clearing: assert property (@(posedge clk) disable iff (rst)
    busy |-> !step)
    else $error("ring stepped during the clearing pass");

  a_bypass_same_slot: assert property (@(posedge clk) disable iff (rst)
    step && (idx_next == idx) |=> rd_data == $past(err))
    else $error("ring read of a rewritten slot is stale");

  a_clear_done_clean: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> (idx == '0) && (sum == '0) && (rd_data == '0))
    else $error("ring state not clean after clearing pass");

endmodule

`default_nettype wire

// ----- hw/rtl/pid_windowed_integral.sv -----
// ----------------------------------------------------------------------------
// pid_windowed_integral
// PID controller in Q8.8 with an integral over a moving window of errors.
// ----------------------------------------------------------------------------
// An accepted input passes every register stage, input register to output register,
// before m_tvalid rises.
// Throughput: one item per cycle unless the ring clear or an output stall holds
// it; the ring update and all multiplies are registered; stages stall only when full.
// After rst the error ring is cleared one entry per cycle, all WINDOW_DEPTH entries,
// with s_tready held low; configuration writes are taken throughout.
// rst is synchronous and active high; gains reset to 0, out_limit to the
// largest positive value, and the window to min(1024, WINDOW_DEPTH).
`default_nettype none

module pid_windowed_integral #(
  parameter int WINDOW_DEPTH = pwi_pkg::DEF_WINDOW_DEPTH,
  parameter int STEP_MS      = pwi_pkg::DEF_STEP_MS
) (
  input  logic                                clk,
  input  logic                                rst,
  // Input items: measured [15:0], target [31:16].
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [pwi_pkg::IN_DATA_W-1:0]       s_tdata,
  // Result items: drive [31:0].
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [pwi_pkg::OUT_DATA_W-1:0]      m_tdata,
  // Configuration writes; index follows the register list.
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [pwi_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [pwi_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import pwi_pkg::*;

  // Datapath widths, following from the package widths and the two parameters.
  localparam int AW    = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int SUM_W = ERR_W + AW + 1;
  localparam int SMW   = $clog2(STEP_MS + 1);
  localparam int PW    = GAIN_W + ERR_W;
  localparam int IPW   = GAIN_W + SUM_W;
  localparam int IW    = IPW + SMW + 1;
  localparam int DPW   = GAIN_W + DIFF_W;
  localparam int DW    = DPW - 1;
  localparam int TW    = IW + 2;
  localparam int YW    = TW - 8;
  localparam int RW    = SMW + 1;
  localparam int QSW   = DW + SMW;

  // Reciprocal of STEP_MS for the exact floor division of the derivative term.
  // With K = DW + clog2(STEP_MS) + 1 the estimate is the quotient or one below.
  localparam int K   = DW + $clog2(STEP_MS) + 1;
  localparam int MW  = DW + 2;
  localparam int MLW = MW / 2;
  localparam int MHW = MW - MLW;
  localparam int PRW = DW + MW + 1;
  localparam logic [63:0]    RECIP = (64'd1 << K) / 64'(STEP_MS);
  localparam logic [MLW-1:0] M_LO  = MLW'(RECIP);
  localparam logic [MHW-1:0] M_HI  = MHW'(RECIP >> MLW);

  localparam logic signed [SMW:0]   STEP_S = (SMW + 1)'(STEP_MS);
  localparam logic [SMW-1:0]        STEP_U = SMW'(STEP_MS);
  localparam logic [WIN_W-1:0]      WIN_RST =
    (WIN_RESET > WINDOW_DEPTH) ? WIN_W'(WINDOW_DEPTH) : WIN_W'(WIN_RESET);
  localparam logic signed [YW-1:0]  OUT_MIN = YW'(-64'sd2147483648);

  localparam int NSTG = 11;

  // Configuration registers.
  logic signed [GAIN_W-1:0] kp_gain;
  logic signed [GAIN_W-1:0] ki_gain;
  logic signed [GAIN_W-1:0] kd_gain;
  logic [WIN_W-1:0]         window;
  logic signed [OUT_W-1:0]  out_limit;
  logic [WIN_W-1:0]         win_raw;

  assign cfg_ready = 1'b1;
  assign win_raw   = cfg_data[WIN_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      kp_gain   <= '0;
      ki_gain   <= '0;
      kd_gain   <= '0;
      window    <= WIN_RST;
      out_limit <= OUT_W'(32'h7FFF_FFFF);
    end else if (cfg_valid) begin
      case (pwi_reg_t'(cfg_index))
        REG_KP:     kp_gain   <= cfg_data[GAIN_W-1:0];
        REG_KI:     ki_gain   <= cfg_data[GAIN_W-1:0];
        REG_KD:     kd_gain   <= cfg_data[GAIN_W-1:0];
        // A window longer than the ring saturates to the ring depth.
        REG_WINDOW: window    <= (32'(win_raw) > 32'(WINDOW_DEPTH)) ?
                                 WIN_W'(WINDOW_DEPTH) : win_raw;
        REG_LIMIT:  out_limit <= cfg_data[OUT_W-1:0];
        default:    ;
      endcase
    end
  end

  // Pipeline flow control: a stage may load when it is empty or when the
  // stage after it loads too, so bubbles are squeezed out under backpressure.
  logic [NSTG-1:0] v;
  logic [NSTG-1:0] load;
  logic            busy;

  always_comb begin
    load[NSTG-1] = !v[NSTG-1] || m_tready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      load[k] = !v[k] || load[k+1];
    end
  end

  assign s_tready = load[0] && !busy;
  assign m_tvalid = v[NSTG-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (load[0]) begin
        v[0] <= s_tvalid && s_tready;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (load[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  // Stage 0: input register.
  logic signed [MEAS_W-1:0] meas0;
  logic signed [MEAS_W-1:0] tgt0;

  always_ff @(posedge clk) begin
    if (load[0]) begin
      meas0 <= s_tdata[MEAS_W-1:0];
      tgt0  <= s_tdata[2*MEAS_W-1:MEAS_W];
    end
  end

  // Stage 1: error, ring update, window sum and derivative.
  logic signed [ERR_W-1:0]  err0;
  logic signed [ERR_W-1:0]  err1;
  logic signed [SUM_W-1:0]  sum1;
  logic signed [DIFF_W-1:0] diff1;
  logic                     ring_step;

  assign err0      = ERR_W'(tgt0) - ERR_W'(meas0);
  assign ring_step = load[1] && v[0];

  pwi_ring #(
    .DEPTH (WINDOW_DEPTH),
    .SUM_W (SUM_W)
  ) u_ring (
    .clk    (clk),
    .rst    (rst),
    .step   (ring_step),
    .err    (err0),
    .window (window),
    .busy   (busy),
    .sum    (sum1),
    .diff   (diff1)
  );

  always_ff @(posedge clk) begin
    if (load[1]) begin
      err1 <= err0;
    end
  end

  // Stage 2: the three gain products.
  logic signed [PW-1:0]  p2;
  logic signed [IPW-1:0] ip2;
  logic signed [DPW-1:0] dp2;

  always_ff @(posedge clk) begin
    if (load[2]) begin
      p2  <= PW'(kp_gain) * PW'(err1);
      ip2 <= IPW'(ki_gain) * IPW'(sum1);
      dp2 <= DPW'(kd_gain) * DPW'(diff1);
    end
  end

  // Stage 3: integral term times STEP_MS; magnitude of the derivative product.
  logic signed [PW-1:0] p3;
  logic signed [IW-1:0] is3;
  logic                 dneg3;
  logic [DW-1:0]        a3;

  always_ff @(posedge clk) begin
    if (load[3]) begin
      p3    <= p2;
      is3   <= IW'(ip2) * IW'(STEP_S);
      dneg3 <= dp2[DPW-1];
      a3    <= dp2[DPW-1] ? DW'(-dp2) : DW'(dp2);
    end
  end

  // Stage 4: partial products of magnitude times reciprocal.
  logic signed [PW-1:0] p4;
  logic signed [IW-1:0] is4;
  logic                 dneg4;
  logic [DW-1:0]        a4;
  logic [DW+MLW-1:0]    pl4;
  logic [DW+MHW-1:0]    ph4;

  always_ff @(posedge clk) begin
    if (load[4]) begin
      p4    <= p3;
      is4   <= is3;
      dneg4 <= dneg3;
      a4    <= a3;
      pl4   <= (DW + MLW)'(a3) * (DW + MLW)'(M_LO);
      ph4   <= (DW + MHW)'(a3) * (DW + MHW)'(M_HI);
    end
  end

  // Stage 5: quotient estimate.
  logic signed [PW-1:0] p5;
  logic signed [IW-1:0] is5;
  logic                 dneg5;
  logic [DW-1:0]        a5;
  logic [DW-1:0]        q0_5;
  logic [PRW-1:0]       prod4;

  assign prod4 = (PRW'(ph4) << MLW) + PRW'(pl4);

  always_ff @(posedge clk) begin
    if (load[5]) begin
      p5    <= p4;
      is5   <= is4;
      dneg5 <= dneg4;
      a5    <= a4;
      q0_5  <= DW'(prod4 >> K);
    end
  end

  // Stage 6: estimate times STEP_MS.
  logic signed [PW-1:0] p6;
  logic signed [IW-1:0] is6;
  logic                 dneg6;
  logic [DW-1:0]        a6;
  logic [DW-1:0]        q0_6;
  logic [QSW-1:0]       q0s6;

  always_ff @(posedge clk) begin
    if (load[6]) begin
      p6    <= p5;
      is6   <= is5;
      dneg6 <= dneg5;
      a6    <= a5;
      q0_6  <= q0_5;
      q0s6  <= QSW'(q0_5) * QSW'(STEP_U);
    end
  end

  // Stage 7: remainder of the estimate, below twice STEP_MS.
  logic signed [PW-1:0] p7;
  logic signed [IW-1:0] is7;
  logic                 dneg7;
  logic [DW-1:0]        q0_7;
  logic [RW-1:0]        r7;
  logic [QSW-1:0]       rem6;

  assign rem6 = QSW'(a6) - q0s6;

  always_ff @(posedge clk) begin
    if (load[7]) begin
      p7    <= p6;
      is7   <= is6;
      dneg7 <= dneg6;
      q0_7  <= q0_6;
      r7    <= RW'(rem6);
    end
  end

  // Stage 8: corrected quotient, floored toward minus infinity.
  logic signed [PW-1:0] p8;
  logic signed [IW-1:0] is8;
  logic signed [DW:0]   dq8;
  logic                 q_up;
  logic                 r_nz;
  logic [DW:0]          mag7;

  always_comb begin
    q_up = (r7 >= RW'(STEP_U));
    r_nz = (r7 != '0) && (r7 != RW'(STEP_U));
    mag7 = {1'b0, q0_7} + (DW + 1)'(q_up) + (DW + 1)'(dneg7 && r_nz);
  end

  always_ff @(posedge clk) begin
    if (load[8]) begin
      p8  <= p7;
      is8 <= is7;
      dq8 <= dneg7 ? -$signed(mag7) : $signed(mag7);
    end
  end

  // Stage 9: total in Q16.16, floored to Q8.8.
  logic signed [YW-1:0] y9;
  logic signed [TW-1:0] total8;

  assign total8 = TW'(p8) + TW'(is8) + TW'(dq8);

  always_ff @(posedge clk) begin
    if (load[9]) begin
      y9 <= YW'(total8 >>> 8);
    end
  end

  // Stage 10: output register with upper clip at out_limit and the floor of
  // the signed 32-bit range.
  logic [OUT_W-1:0] drive_q;

  always_ff @(posedge clk) begin
    if (load[10]) begin
      if (y9 > YW'(out_limit)) begin
        drive_q <= out_limit;
      end else if (y9 < OUT_MIN) begin
        drive_q <= OUT_W'(OUT_MIN);
      end else begin
        drive_q <= OUT_W'(y9);
      end
    end
  end

  assign m_tdata = drive_q;

  a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (rst)
    busy |-> !s_tready)
    else $error("input accepted during the ring clearing pass");

  a_stall_holds_stage9: assert property (@(posedge clk) disable iff (rst)
    v[9] && !load[10] |=> v[9] && $stable(y9))
    else $error("stalled stage lost its item");

  a_drain_empties_output: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !v[NSTG-2] |=> !m_tvalid)
    else $error("result repeated after it was taken");

endmodule

`default_nettype wire

// ----- bench/pwi_drive_checker.sv -----
// ----------------------------------------------------------------------------
// pwi_drive_checker
// Watches the configuration, sample and drive channels of the windowed PID.
// Keeps its own copy of the gains, window ring and error sum, predicts the
// drive value of every accepted sample and compares each drive transaction
// with the oldest prediction.
// ----------------------------------------------------------------------------
module pwi_drive_checker #(
  parameter int WINDOW_DEPTH = pwi_pkg::DEF_WINDOW_DEPTH,
  parameter int STEP_MS      = pwi_pkg::DEF_STEP_MS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  input  logic                           s_tready,
  input  logic [pwi_pkg::IN_DATA_W-1:0]  s_tdata,
  input  logic                           m_tvalid,
  input  logic                           m_tready,
  input  logic [pwi_pkg::OUT_DATA_W-1:0] m_tdata,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [pwi_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pwi_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             drive_mismatches,
  output int                             drives_owed
);
  import pwi_pkg::*;

  localparam longint DRIVE_FLOOR = -(longint'(1) <<< (OUT_W - 1));

  logic signed [GAIN_W-1:0] kp_q;
  logic signed [GAIN_W-1:0] ki_q;
  logic signed [GAIN_W-1:0] kd_q;
  int unsigned              win_len;
  logic signed [OUT_W-1:0]  drive_ceiling;

  logic signed [ERR_W-1:0]  err_hist [WINDOW_DEPTH];
  int unsigned              hist_pos;
  longint                   hist_sum;
  logic signed [ERR_W-1:0]  prev_err;

  logic [OUT_W-1:0]         pending_drives [$];

  longint                   err_v;
  longint                   diff_v;
  longint                   total_v;
  longint                   drive_v;
  logic [OUT_W-1:0]         want_drive;

  // Division rounded toward minus infinity; the divisors here are positive.
  function automatic longint floor_div(longint num, longint den);
    longint q;
    q = num / den;
    if ((num % den) != 0 && num < 0) q = q - 1;
    return q;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      kp_q          = '0;
      ki_q          = '0;
      kd_q          = '0;
      win_len       = (WIN_RESET > WINDOW_DEPTH) ? WINDOW_DEPTH : WIN_RESET;
      drive_ceiling = {1'b0, {(OUT_W-1){1'b1}}};
      foreach (err_hist[i]) err_hist[i] = '0;
      hist_pos      = 0;
      hist_sum      = 0;
      prev_err      = '0;
      pending_drives.delete();
      drive_mismatches = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (pwi_reg_t'(cfg_index))
          REG_KP:     kp_q = cfg_data[GAIN_W-1:0];
          REG_KI:     ki_q = cfg_data[GAIN_W-1:0];
          REG_KD:     kd_q = cfg_data[GAIN_W-1:0];
          REG_WINDOW: win_len = (int'(cfg_data[WIN_W-1:0]) > WINDOW_DEPTH) ?
                                WINDOW_DEPTH : int'(cfg_data[WIN_W-1:0]);
          REG_LIMIT:  drive_ceiling = cfg_data[OUT_W-1:0];
          default: ;
        endcase
      end

      if (s_tvalid && s_tready) begin
        err_v = longint'($signed(s_tdata[IN_DATA_W-1:MEAS_W]))
              - longint'($signed(s_tdata[MEAS_W-1:0]));
        if (hist_pos >= WINDOW_DEPTH) hist_pos = 0;
        // The slot being replaced leaves the sum, the new error enters it.
        hist_sum = hist_sum - longint'(err_hist[hist_pos]) + err_v;
        err_hist[hist_pos] = ERR_W'(err_v);
        hist_pos++;
        if (hist_pos >= win_len || hist_pos >= WINDOW_DEPTH) hist_pos = 0;
        diff_v   = err_v - longint'(prev_err);
        prev_err = ERR_W'(err_v);
        total_v  = longint'(kp_q) * err_v
                 + longint'(ki_q) * hist_sum * STEP_MS
                 + floor_div(longint'(kd_q) * diff_v, STEP_MS);
        drive_v  = floor_div(total_v, 256);
        if (drive_v > longint'(drive_ceiling)) drive_v = longint'(drive_ceiling);
        if (drive_v < DRIVE_FLOOR) drive_v = DRIVE_FLOOR;
        pending_drives.push_back(OUT_W'(drive_v));
      end

      if (m_tvalid && m_tready) begin
        if (pending_drives.size() == 0) begin
          drive_mismatches++;
          $display("%0t unexpected drive transaction: expected none, actual %0d",
                   $time, $signed(m_tdata[OUT_W-1:0]));
        end else begin
          want_drive = pending_drives.pop_front();
          if (m_tdata[OUT_W-1:0] !== want_drive) begin
            drive_mismatches++;
            $display("%0t drive mismatch: expected %0d, actual %0d",
                     $time, $signed(want_drive), $signed(m_tdata[OUT_W-1:0]));
          end
        end
      end
    end
    drives_owed <= pending_drives.size();
  end

endmodule

// ----- bench/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the windowed-integral PID controller.
// Drives directed corner samples and register settings, then randomized
// phases of control-loop-like and full-range samples under random idling
// and back-pressure; a separate checker predicts and compares every drive.
// ----------------------------------------------------------------------------
module tb_top;
  import pwi_pkg::*;

  localparam int WINDOW_DEPTH   = DEF_WINDOW_DEPTH;
  localparam int STEP_MS        = DEF_STEP_MS;
  localparam int IDLE_PCT       = 19;
  localparam int HOLD_CYCLES    = 400;
  // The longest correct stretch without any transaction is the ring clear
  // after reset or the receiver hold-off; allow well beyond both.
  localparam int WATCHDOG_LIMIT = 4 * WINDOW_DEPTH;
  localparam int PHASES         = 12;
  localparam int PHASE_ITEMS    = 116;
  // The tail wait before the verdict is longer than the path of a result
  // through the block from its sample.
  localparam int DRAIN_CYCLES   = 24;

  localparam logic signed [GAIN_W-1:0] GAIN_MAX = {1'b0, {(GAIN_W-1){1'b1}}};
  localparam logic signed [GAIN_W-1:0] GAIN_MIN = {1'b1, {(GAIN_W-1){1'b0}}};
  localparam logic signed [MEAS_W-1:0] MEAS_MAX = {1'b0, {(MEAS_W-1){1'b1}}};
  localparam logic signed [MEAS_W-1:0] MEAS_MIN = {1'b1, {(MEAS_W-1){1'b0}}};
  localparam logic signed [OUT_W-1:0]  OUT_MAX  = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic signed [OUT_W-1:0]  OUT_MIN  = {1'b1, {(OUT_W-1){1'b0}}};

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata   = '0;
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  // When calm is set neither side idles; hold_req asks the receiver for one
  // long hold-off, and the receiver marks it served in hold_done.
  logic calm      = 1'b0;
  logic hold_req  = 1'b0;
  logic hold_done = 1'b0;

  int drive_mismatches;
  int drives_owed;
  int quiet_cycles = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  pid_windowed_integral #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .STEP_MS      (STEP_MS)
  ) u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  pwi_drive_checker #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .STEP_MS      (STEP_MS)
  ) u_chk (
    .clk              (clk),
    .rst              (rst),
    .s_tvalid         (s_tvalid),
    .s_tready         (s_tready),
    .s_tdata          (s_tdata),
    .m_tvalid         (m_tvalid),
    .m_tready         (m_tready),
    .m_tdata          (m_tdata),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .drive_mismatches (drive_mismatches),
    .drives_owed      (drives_owed)
  );

  // Drive receiver. Normally it stalls at random; on request it holds off for
  // a long stretch so that the pipeline fills and the block stalls its input.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        m_tready <= 1'b0;
        for (int n = 0; n < HOLD_CYCLES; n++) @(posedge clk);
        hold_done = 1'b1;
        m_tready <= 1'b1;
      end else if (calm) begin
        m_tready <= 1'b1;
      end else begin
        m_tready <= ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // Watchdog: any transaction on any channel restarts the count.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offers one sample and returns at the edge where the transaction is taken.
  // Each cycle before the offer is idle with the idle percentage, and tvalid
  // is only lowered when such a cycle comes, so back-to-back samples keep it
  // high.
  task automatic send_sample(input logic [MEAS_W-1:0] meas, input logic [MEAS_W-1:0] tgt);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {tgt, meas};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Stops offering samples and waits until every predicted drive has come.
  task automatic settle();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (drives_owed != 0);
  endtask

  // One configuration transaction; cfg_valid is left high for the next one.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Writes every register, after a write to an unused index that the block
  // must ignore. Gains and the limit are sign-extended to the data width.
  task automatic load_settings(input logic signed [GAIN_W-1:0] kp,
                               input logic signed [GAIN_W-1:0] ki,
                               input logic signed [GAIN_W-1:0] kd,
                               input logic [WIN_W-1:0] win,
                               input logic signed [OUT_W-1:0] lim);
    write_reg(CFG_IDX_W'($urandom_range(int'(REG_LIMIT) + 1, (1 << CFG_IDX_W) - 1)),
              $urandom);
    write_reg(REG_KP, kp);
    write_reg(REG_KI, ki);
    write_reg(REG_KD, kd);
    write_reg(REG_WINDOW, win);
    write_reg(REG_LIMIT, lim);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic signed [GAIN_W-1:0] pick_gain();
    case ($urandom_range(0, 3))
      0:       return GAIN_MIN;
      1:       return GAIN_MAX;
      default: return GAIN_W'($urandom);
    endcase
  endfunction

  function automatic logic [MEAS_W-1:0] pick_corner();
    case ($urandom_range(0, 3))
      0:       return MEAS_MIN;
      1:       return MEAS_MAX;
      2:       return '0;
      default: return '1;
    endcase
  endfunction

  initial begin
    logic [WIN_W-1:0]        win_pick;
    logic signed [OUT_W-1:0] lim_pick;
    logic [MEAS_W-1:0]       setpoint;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // With the reset gains every drive must be zero, even at the largest
    // errors. These samples wait out the ring clear after reset.
    send_sample(MEAS_MIN, MEAS_MAX);
    send_sample(MEAS_MAX, MEAS_MIN);
    settle();

    // An over-range window saturates to the ring depth. Largest errors of
    // both signs, zero error, a negative error and a small positive error.
    load_settings(16'sh0100, 16'sh0001, GAIN_MAX, '1, OUT_MAX);
    send_sample(16'h0000, 16'h0000);
    send_sample(MEAS_MIN, MEAS_MAX);
    send_sample(MEAS_MAX, MEAS_MIN);
    send_sample(MEAS_MAX, MEAS_MAX);
    send_sample(16'h1234, 16'hFFFF);
    send_sample(16'hFFFF, 16'h0000);
    settle();

    // The window shrinks below the current ring position: the slot at the
    // position is written once more before the index wraps. A small positive
    // limit clips the output from above.
    load_settings(GAIN_MIN, GAIN_MAX, GAIN_MIN, 11'd4, 32'sh0000_0100);
    send_sample(MEAS_MAX, MEAS_MIN);
    send_sample(MEAS_MIN, MEAS_MAX);
    send_sample(16'h0100, 16'h0080);
    send_sample(16'h0080, 16'h0100);
    send_sample(MEAS_MIN, MEAS_MIN);
    send_sample(16'h7F00, 16'h8001);
    settle();

    // A zero window behaves like a window of one; the most negative limit
    // clips every drive to the bottom of the range.
    load_settings(GAIN_MAX, GAIN_MIN, GAIN_MAX, 11'd0, OUT_MIN);
    send_sample(MEAS_MIN, MEAS_MAX);
    send_sample(MEAS_MAX, MEAS_MIN);
    send_sample(16'h0000, 16'h0001);
    send_sample(16'h0001, 16'h0000);
    settle();

    // Fractional gains, where the floor of each quotient matters.
    load_settings(16'sh0080, 16'shFF80, 16'sh0003, 11'd1, 32'sh0001_0000);
    send_sample(16'h0001, 16'h0000);
    send_sample(16'h0000, 16'h0007);
    send_sample(16'hFFF3, 16'h0002);
    send_sample(16'h0005, 16'hFFFB);
    settle();

    for (int p = 0; p < PHASES; p++) begin
      settle();
      calm = (p == 3);
      if (p == 0) begin
        // Saturation run: a run of large negative errors drives the
        // integral below the bottom of the output range, then large positive
        // errors push it above the limit.
        load_settings(pick_gain(), GAIN_MAX, pick_gain(), 11'd1024, OUT_MAX);
        for (int i = 0; i < 150; i++) begin
          if (i < 60) send_sample({8'h7F, 8'($urandom)}, {8'h80, 8'($urandom)});
          else        send_sample({8'h80, 8'($urandom)}, {8'h7F, 8'($urandom)});
        end
      end else begin
        case ($urandom_range(0, 5))
          0:       win_pick = '0;
          1:       win_pick = 11'd1;
          2:       win_pick = WIN_W'($urandom_range(2, 16));
          3:       win_pick = WIN_W'($urandom_range(17, WINDOW_DEPTH));
          4:       win_pick = WIN_W'($urandom_range(WINDOW_DEPTH + 1, (1 << WIN_W) - 1));
          default: win_pick = WIN_W'(WINDOW_DEPTH);
        endcase
        case ($urandom_range(0, 3))
          0:       lim_pick = OUT_MAX;
          1:       lim_pick = OUT_MIN;
          2:       lim_pick = OUT_W'($urandom);
          default: lim_pick = OUT_W'($urandom_range(0, 1 << 21)) - (OUT_W'(1) << 20);
        endcase
        load_settings(pick_gain(), pick_gain(), pick_gain(), win_pick, lim_pick);
        setpoint = MEAS_W'($urandom);
        for (int i = 0; i < PHASE_ITEMS; i++) begin
          // One phase holds the receiver off while samples keep coming; another
          // pauses the sender halfway until every drive is back.
          if (p == 5 && i == 8) hold_req = 1'b1;
          if (p == 7 && i == PHASE_ITEMS / 2) settle();
          case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: send_sample(MEAS_W'($urandom), MEAS_W'($urandom));
            // A loop in regulation: the measurement wanders near the setpoint.
            5, 6, 7: send_sample(setpoint + MEAS_W'($urandom_range(0, 255)) - MEAS_W'(128),
                                 setpoint);
            default: send_sample(pick_corner(), pick_corner());
          endcase
        end
      end
    end

    settle();
    calm = 1'b0;
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (drive_mismatches == 0 && drives_owed == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/pwi_pkg.sv
hw/rtl/pwi_ring.sv
hw/rtl/pid_windowed_integral.sv
bench/pwi_drive_checker.sv
bench/tb_top.sv
